### hw/rtl/q2rm_pkg.sv
package q2rm_pkg;

    localparam int FRAC_BITS_DEF = 14;
    localparam int DATA_W        = 16;
    localparam int PROD_W        = 2 * DATA_W;
    // Numerators reach about 2^32 in magnitude; keep headroom for the sign.
    localparam int NUM_W         = PROD_W + 4;
    // Squared norm is at most 4 * 2^30.
    localparam int DEN_W         = PROD_W + 1;
    // Partial remainder stays at or below the norm and is shifted once per step after the first.
    localparam int REM_W         = DEN_W + 1;
    localparam int LANES         = 9;

endpackage

### hw/rtl/quaternion_to_rotation_matrix.sv
// Channel   Direction  Handshake             Beat contents
// --------  ---------  --------------------  --------------------------------------
// in        sink       in_valid / in_ready   q_scalar, q_i, q_j, q_k (Q1.14)
// out       source     out_valid / out_ready m00..m22 (Q1.14), degenerate
//
// One beat per cycle sustained while out_ready stays high. The stages are the
// input register, products, sums, magnitude/clamp, FRAC_BITS + 2 divider steps
// and the rounding/output register. The divider is nine restoring lanes, one quotient
// bit per stage. Each stage holds when the stage after it is full and holding,
// so bubbles close up and no beat is lost or repeated. Reset clears only the
// stage valid bits.
module quaternion_to_rotation_matrix #(
    parameter int FRAC_BITS = q2rm_pkg::FRAC_BITS_DEF
) (
    input  logic                                clk,
    input  logic                                rst_n,
    input  logic                                in_valid,
    output logic                                in_ready,
    input  logic signed [q2rm_pkg::DATA_W-1:0]  q_scalar,
    input  logic signed [q2rm_pkg::DATA_W-1:0]  q_i,
    input  logic signed [q2rm_pkg::DATA_W-1:0]  q_j,
    input  logic signed [q2rm_pkg::DATA_W-1:0]  q_k,
    output logic                                out_valid,
    input  logic                                out_ready,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m00,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m01,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m02,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m10,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m11,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m12,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m20,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m21,
    output logic signed [q2rm_pkg::DATA_W-1:0]  m22,
    output logic                                degenerate
);
    import q2rm_pkg::*;

    // Quotient of mag * 2^(F+1) / den, one extra bit for the rounding step.
    localparam int QW = FRAC_BITS + 2;
    // Stages: 0 input, 1 products, 2 sums, 3 magnitude, 4..3+QW divider, 4+QW out.
    localparam int L  = QW + 5;
    localparam int DS = 3;
    // Rounding width: wide enough for the quotient and for a full output field.
    localparam int SW = (QW + 1 > DATA_W) ? QW + 1 : DATA_W;

    // Handshake: per-stage valid and advance chain.
    logic [L-1:0] v_reg;
    logic [L-1:0] en;

    always_comb
    begin
        en[L-1] = !v_reg[L-1] || out_ready;
        for (int s = L - 2; s >= 0; s--)
        begin
            en[s] = !v_reg[s] || en[s+1];
        end
    end

    assign in_ready  = en[0];
    assign out_valid = v_reg[L-1];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            v_reg <= '0;
        end
        else
        begin
            if (en[0])
            begin
                v_reg[0] <= in_valid;
            end
            for (int s = 1; s < L; s++)
            begin
                if (en[s])
                begin
                    v_reg[s] <= v_reg[s-1];
                end
            end
        end
    end

    // Stage 0: input register.
    logic signed [DATA_W-1:0] s_reg, i_reg, j_reg, k_reg;

    always_ff @(posedge clk)
    begin
        if (en[0])
        begin
            s_reg <= q_scalar;
            i_reg <= q_i;
            j_reg <= q_j;
            k_reg <= q_k;
        end
    end

    // Stage 1: the ten products.
    logic signed [PROD_W-1:0] ii_reg, jj_reg, kk_reg, ss_reg;
    logic signed [PROD_W-1:0] ij_reg, ik_reg, is_reg, jk_reg, js_reg, ks_reg;

    always_ff @(posedge clk)
    begin
        if (en[1])
        begin
            ii_reg <= i_reg * i_reg;
            jj_reg <= j_reg * j_reg;
            kk_reg <= k_reg * k_reg;
            ss_reg <= s_reg * s_reg;
            ij_reg <= i_reg * j_reg;
            ik_reg <= i_reg * k_reg;
            is_reg <= i_reg * s_reg;
            jk_reg <= j_reg * k_reg;
            js_reg <= j_reg * s_reg;
            ks_reg <= k_reg * s_reg;
        end
    end

    // Stage 2: squared norm and the nine numerators.
    logic signed [NUM_W-1:0] xii, xjj, xkk, xss, xij, xik, xis, xjk, xjs, xks, xn;
    logic signed [NUM_W-1:0] num_next [LANES];
    logic signed [NUM_W-1:0] num_reg  [LANES];
    logic [DEN_W-1:0]        n_reg;

    always_comb
    begin
        xii = NUM_W'(ii_reg);
        xjj = NUM_W'(jj_reg);
        xkk = NUM_W'(kk_reg);
        xss = NUM_W'(ss_reg);
        xij = NUM_W'(ij_reg);
        xik = NUM_W'(ik_reg);
        xis = NUM_W'(is_reg);
        xjk = NUM_W'(jk_reg);
        xjs = NUM_W'(js_reg);
        xks = NUM_W'(ks_reg);
        xn  = xii + xjj + xkk + xss;
        num_next[0] = xn - ((xjj + xkk) <<< 1);
        num_next[1] = (xij + xks) <<< 1;
        num_next[2] = (xik - xjs) <<< 1;
        num_next[3] = (xij - xks) <<< 1;
        num_next[4] = xn - ((xii + xkk) <<< 1);
        num_next[5] = (xjk + xis) <<< 1;
        num_next[6] = (xik + xjs) <<< 1;
        num_next[7] = (xjk - xis) <<< 1;
        num_next[8] = xn - ((xii + xjj) <<< 1);
    end

    always_ff @(posedge clk)
    begin
        if (en[2])
        begin
            num_reg <= num_next;
            n_reg   <= xn[DEN_W-1:0];
        end
    end

    // Stage 3 and divider: entry t of these arrays belongs to stage DS + t.
    logic [REM_W-1:0] dr_reg  [QW+1][LANES];
    logic [QW-1:0]    dq_reg  [QW+1][LANES];
    logic [LANES-1:0] neg_reg [QW+1];
    logic [DEN_W-1:0] den_reg [QW+1];
    logic             dg_reg  [QW+1];

    logic [NUM_W-1:0] mag      [LANES];
    logic             deg_next;

    always_comb
    begin
        deg_next = (n_reg == '0);
        for (int l = 0; l < LANES; l++)
        begin
            mag[l] = num_reg[l][NUM_W-1] ? NUM_W'(-num_reg[l]) : NUM_W'(num_reg[l]);
            // Clamp the magnitude to the norm, which caps the entry at one.
            if (mag[l] > NUM_W'(n_reg))
            begin
                mag[l] = NUM_W'(n_reg);
            end
        end
    end

    logic [REM_W-1:0] trial  [QW][LANES];
    logic             ge     [QW][LANES];

    always_comb
    begin
        for (int t = 0; t < QW; t++)
        begin
            for (int l = 0; l < LANES; l++)
            begin
                // First step tests the integer bit without a shift.
                trial[t][l] = (t == 0) ? dr_reg[t][l] : {dr_reg[t][l][REM_W-2:0], 1'b0};
                ge[t][l]    = trial[t][l] >= REM_W'(den_reg[t]);
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[DS])
        begin
            for (int l = 0; l < LANES; l++)
            begin
                dr_reg[0][l]  <= mag[l][REM_W-1:0];
                dq_reg[0][l]  <= '0;
                neg_reg[0][l] <= num_reg[l][NUM_W-1];
            end
            // Substitute a unit norm for the zero quaternion; its result is overridden.
            den_reg[0] <= deg_next ? DEN_W'(1) : n_reg;
            dg_reg[0]  <= deg_next;
        end
        for (int t = 0; t < QW; t++)
        begin
            if (en[DS+1+t])
            begin
                for (int l = 0; l < LANES; l++)
                begin
                    dr_reg[t+1][l] <= ge[t][l] ? trial[t][l] - REM_W'(den_reg[t])
                                               : trial[t][l];
                    dq_reg[t+1][l] <= {dq_reg[t][l][QW-2:0], ge[t][l]};
                end
                neg_reg[t+1] <= neg_reg[t];
                den_reg[t+1] <= den_reg[t];
                dg_reg[t+1]  <= dg_reg[t];
            end
        end
    end

    // Output stage: round half away from zero, saturate, apply sign; identity for a zero quaternion.
    localparam logic [SW-1:0] ONE_Q = SW'(1) << FRAC_BITS;

    logic [SW-1:0]      rq     [LANES];
    logic [SW-1:0]      sv     [LANES];
    logic [DATA_W-1:0]  m_next [LANES];
    logic [DATA_W-1:0]  m_reg  [LANES];
    logic               deg_reg;

    always_comb
    begin
        for (int l = 0; l < LANES; l++)
        begin
            rq[l] = (SW'(dq_reg[QW][l]) + SW'(1)) >> 1;
            if (rq[l] > ONE_Q)
            begin
                rq[l] = ONE_Q;
            end
            sv[l] = neg_reg[QW][l] ? SW'(-rq[l]) : rq[l];
            if (dg_reg[QW])
            begin
                m_next[l] = (l == 0 || l == 4 || l == 8) ? ONE_Q[DATA_W-1:0] : '0;
            end
            else
            begin
                m_next[l] = sv[l][DATA_W-1:0];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (en[L-1])
        begin
            m_reg   <= m_next;
            deg_reg <= dg_reg[QW];
        end
    end

    assign m00 = m_reg[0];
    assign m01 = m_reg[1];
    assign m02 = m_reg[2];
    assign m10 = m_reg[3];
    assign m11 = m_reg[4];
    assign m12 = m_reg[5];
    assign m20 = m_reg[6];
    assign m21 = m_reg[7];
    assign m22 = m_reg[8];
    assign degenerate = deg_reg;

endmodule

### hw/rtl/q2rm_checker.sv
module q2rm_checker (
    input logic                                clk,
    input logic                                rst_n,
    input logic                                in_valid,
    input logic                                in_ready,
    input logic signed [q2rm_pkg::DATA_W-1:0]  q_scalar,
    input logic signed [q2rm_pkg::DATA_W-1:0]  q_i,
    input logic signed [q2rm_pkg::DATA_W-1:0]  q_j,
    input logic signed [q2rm_pkg::DATA_W-1:0]  q_k,
    input logic                                out_valid,
    input logic                                out_ready,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m00,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m01,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m02,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m10,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m11,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m12,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m20,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m21,
    input logic signed [q2rm_pkg::DATA_W-1:0]  m22,
    input logic                                degenerate
);
    // Hold a stalled result beat (checks m00, m11, m22, m01 and degenerate).
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && !out_ready |=> out_valid && $stable(m00) && $stable(m11)
            && $stable(m22) && $stable(m01) && $stable(degenerate))
        else $error("result beat changed while stalled");

    // Zero quaternion gives zero off-diagonal entries.
    a_degen_offdiag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> m01 == 0 && m02 == 0 && m10 == 0 && m12 == 0
            && m20 == 0 && m21 == 0)
        else $error("degenerate beat has nonzero off-diagonal entry");

    // An empty output register must not block the input side.
    a_no_block: assert property (@(posedge clk) disable iff (!rst_n)
        !out_valid |-> in_ready)
        else $error("input stalled with empty output");

    // Degenerate beats: the three diagonal entries must agree, as they do for the identity.
    a_degen_diag: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid && degenerate |-> m00 == m11 && m11 == m22)
        else $error("degenerate beat diagonal mismatch");

endmodule

bind quaternion_to_rotation_matrix q2rm_checker u_q2rm_checker (.*);

### sim/tb_quaternion_to_rotation_matrix.sv
`timescale 1ns / 1ps

// Scoreboard: predicts the rotation matrix for each accepted quaternion and
// checks result beats in order.
class rot_matrix_board;
    typedef struct {
        logic signed [15:0] m [9];
        logic               degen;
    } matrix_t;

    matrix_t pending_mats [$];
    int      err_count;

    function new();
        err_count = 0;
    endfunction

    // round(num * 2^14 / den), half away from zero, clamped to +/-1.0
    static function logic [15:0] ratio_q14(longint num, longint den);
        bit      neg;
        longint  mag;
        longint  q;
        neg = num < 0;
        mag = neg ? -num : num;
        if (mag > den)
            mag = den;
        mag = mag << 14;
        q = (2 * mag + den) / (2 * den);
        if (q > (1 << 14))
            q = 1 << 14;
        if (neg)
            q = -q;
        return q[15:0];
    endfunction

    function void note_quat(logic signed [15:0] s, logic signed [15:0] i,
                            logic signed [15:0] j, logic signed [15:0] k);
        matrix_t r;
        longint  ls, li, lj, lk, n;
        ls = s; li = i; lj = j; lk = k;
        n = ls*ls + li*li + lj*lj + lk*lk;
        r.degen = (n == 0);
        if (n == 0) begin
            foreach (r.m[x]) r.m[x] = 0;
            r.m[0] = 16'sd16384;
            r.m[4] = 16'sd16384;
            r.m[8] = 16'sd16384;
        end
        else begin
            r.m[0] = ratio_q14(n - 2*(lj*lj + lk*lk), n);
            r.m[1] = ratio_q14(2*(li*lj + lk*ls), n);
            r.m[2] = ratio_q14(2*(li*lk - lj*ls), n);
            r.m[3] = ratio_q14(2*(li*lj - lk*ls), n);
            r.m[4] = ratio_q14(n - 2*(li*li + lk*lk), n);
            r.m[5] = ratio_q14(2*(lj*lk + li*ls), n);
            r.m[6] = ratio_q14(2*(li*lk + lj*ls), n);
            r.m[7] = ratio_q14(2*(lj*lk - li*ls), n);
            r.m[8] = ratio_q14(n - 2*(li*li + lj*lj), n);
        end
        pending_mats.push_back(r);
    endfunction

    task report(string what, int got, int want);
        $display("mismatch %s: got %0d want %0d", what, got, want);
        err_count++;
    endtask

    task check_matrix(logic signed [15:0] m [9], logic degen);
        matrix_t e;
        if (pending_mats.size() == 0) begin
            report("unexpected beat", 1, 0);
            return;
        end
        e = pending_mats.pop_front();
        for (int x = 0; x < 9; x++)
            if (m[x] !== e.m[x])
                report($sformatf("m%0d%0d", x / 3, x % 3), m[x], e.m[x]);
        if (degen !== e.degen)
            report("degenerate", degen, e.degen);
    endtask
endclass

module tb_quaternion_to_rotation_matrix;
    logic clk = 0;
    logic rst_n = 0;
    logic in_valid = 0;
    logic in_ready;
    logic signed [15:0] q_scalar = 0, q_i = 0, q_j = 0, q_k = 0;
    logic out_valid;
    logic out_ready = 0;
    logic signed [15:0] m00, m01, m02, m10, m11, m12, m20, m21, m22;
    logic degenerate;

    // idle/stall percentages per phase; hold_off forces a long receiver stall
    int send_idle_pct = 0;
    int recv_stall_pct = 0;
    int hold_off = 0;
    bit stim_done = 0;

    rot_matrix_board board = new();

    always #1 clk = ~clk;

    quaternion_to_rotation_matrix dut (.*);

    // Send one quaternion beat; hold it until accepted. Valid stays high on
    // return so the next beat can follow with no gap.
    task send_quat(logic signed [15:0] s, logic signed [15:0] i,
                   logic signed [15:0] j, logic signed [15:0] k);
        while ($urandom_range(99) < send_idle_pct) begin
            in_valid <= 0;
            @(negedge clk);
        end
        q_scalar <= s;
        q_i <= i;
        q_j <= j;
        q_k <= k;
        in_valid <= 1;
        @(posedge clk);
        while (!in_ready) @(posedge clk);
        board.note_quat(s, i, j, k);
        @(negedge clk);
    endtask

    // Mostly small-to-mid magnitudes plus full-range and boundary values.
    function logic [15:0] rand_comp();
        case ($urandom_range(5))
            0: return $urandom_range(0, 65535);
            1: return $urandom_range(0, 15) - 8;
            2: return ($urandom_range(1) ? 16'h8000 : 16'h7fff);
            default: return $urandom_range(0, 4095) - 2048;
        endcase
    endfunction

    // Drop valid and wait for every outstanding result.
    task wait_drained();
        in_valid <= 0;
        while (board.pending_mats.size() != 0) @(negedge clk);
        repeat (30) @(negedge clk);
    endtask

    // Receiver: decide ready at each falling edge.
    always @(negedge clk) begin
        if (hold_off > 0) begin
            hold_off <= hold_off - 1;
            out_ready <= 0;
        end
        else
            out_ready <= ($urandom_range(99) >= recv_stall_pct);
    end

    // Check every accepted result beat.
    always @(posedge clk) begin
        if (rst_n && out_valid && out_ready)
            board.check_matrix('{m00, m01, m02, m10, m11, m12, m20, m21, m22},
                               degenerate);
    end

    initial begin
        repeat (7) @(negedge clk);
        rst_n <= 1;
        @(negedge clk);

        // directed: zero, unit axes, extremes, mixed signs, tiny norm
        send_quat(0, 0, 0, 0);
        send_quat(16384, 0, 0, 0);
        send_quat(0, 16384, 0, 0);
        send_quat(0, 0, 16384, 0);
        send_quat(0, 0, 0, 16384);
        send_quat(-16384, 0, 0, 0);
        send_quat(16'sh7fff, 16'sh7fff, 16'sh7fff, 16'sh7fff);
        send_quat(16'sh8000, 16'sh8000, 16'sh8000, 16'sh8000);
        send_quat(16'sh8000, 16'sh7fff, 16'sh8000, 16'sh7fff);
        send_quat(1, 0, 0, 0);
        send_quat(0, 0, 0, -1);
        send_quat(1, 1, 1, 1);
        send_quat(1, -1, 1, -1);
        send_quat(8192, 8192, 8192, 8192);
        send_quat(11585, 11585, 0, 0);
        send_quat(11585, 0, -11585, 0);
        send_quat(16'sh8000, 0, 0, 0);
        send_quat(-1, -1, -1, -1);
        send_quat(3, 1, 0, 0);
        send_quat(0, 0, 0, 0);
        send_quat(16'sh5555, 16'shaaaa, 16'sh5555, 16'shaaaa);
        wait_drained();

        // random phases: none, sender idle, receiver stalling, both
        for (int ph = 0; ph < 4; ph++) begin
            send_idle_pct  = (ph == 1) ? 62 : (ph == 3) ? 20 : 0;
            recv_stall_pct = (ph == 2) ? 62 : (ph == 3) ? 20 : 0;
            if (ph == 2)
                hold_off <= 200; // long stall: the pipe fills and backs up
            for (int n = 0; n < 345; n++) begin
                if (n % 40 == 0)
                    send_quat(0, 0, 0, 0);
                else
                    send_quat(rand_comp(), rand_comp(), rand_comp(), rand_comp());
            end
            // pause until every result is back
            wait_drained();
        end
        stim_done = 1;
    end

    initial begin
        wait (stim_done);
        if (board.err_count == 0)
            $display("tb_quaternion_to_rotation_matrix: clean");
        else
            $display("tb_quaternion_to_rotation_matrix: errors");
        $finish;
    end

    initial begin
        #400000;
        $display("tb_quaternion_to_rotation_matrix: errors");
        $finish;
    end
endmodule
